// File: src/sma_pkg.sv
// Shared types and codes for the stack machine arithmetic unit.
// No dependencies.
package sma_pkg;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_DIV   = 3'd2,
        OP_MUL   = 3'd3,
        OP_MOD   = 3'd4,
        OP_PCHAR = 3'd5,
        OP_PSTR  = 3'd6,
        OP_NOP   = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_DIVZERO = 3'd2,
        ERR_EMPTY   = 3'd3,
        ERR_RANGE   = 3'd4,
        ERR_FULL    = 3'd5
    } t_err;

    localparam logic [6:0] CHAR_NEWLINE = 7'd10;
    localparam logic [31:0] CHAR_LIMIT  = 32'd127;
    localparam logic [31:0] PSTR_BOUND  = 32'd128;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic        char_valid;
        logic [6:0]  char_code;
        logic [2:0]  error_code;
        logic [31:0] top_value;
        logic [5:0]  stack_count;
        logic        last;
    } t_out_item;

    // Shared arithmetic unit control
    typedef struct packed {
        logic start;
        logic is_mul;
        logic want_rem;
    } t_alu_ctl;

endpackage

// File: src/sma_if.sv
// Valid/ready channel interface carrying one item.
// No dependencies.
interface sma_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/sma_alu.sv
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on sma_pkg.
module sma_alu
    import sma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_ctl    i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_mul, r_rem, r_qneg, r_rneg;
    logic [31:0] r_acc, n_acc;   // product or remainder
    logic [31:0] r_sh, n_sh;     // multiplier or dividend/quotient
    logic [31:0] r_b;
    logic        r_done;
    logic [32:0] w_trial;
    logic [31:0] w_rpart;

    assign w_rpart = {r_acc[30:0], r_sh[31]};
    assign w_trial = {r_acc, r_sh[31]} - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        if (r_busy) begin
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
            end
            if (r_mul) begin
                n_acc = {r_acc[30:0], 1'b0} + (r_sh[31] ? r_b : 32'd0);
                n_sh  = {r_sh[30:0], 1'b0};
            end else if (!w_trial[32]) begin
                n_acc = w_trial[31:0];
                n_sh  = {r_sh[30:0], 1'b1};
            end else begin
                n_acc = w_rpart;
                n_sh  = {r_sh[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else begin
                r_busy <= n_busy;
                r_cnt  <= n_cnt;
            end
        end
        if (i_ctl.start) begin
            r_mul  <= i_ctl.is_mul;
            r_rem  <= i_ctl.want_rem;
            r_acc  <= '0;
            r_qneg <= i_a[31] ^ i_b[31];
            r_rneg <= i_a[31];
            if (i_ctl.is_mul) begin
                r_sh <= i_a;
                r_b  <= i_b;
            end else begin
                r_sh <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_b  <= i_b[31] ? (32'd0 - i_b) : i_b;
            end
        end else begin
            r_acc <= n_acc;
            r_sh  <= n_sh;
        end
    end

    assign o_done = r_done;
    always_comb begin
        if (r_mul) begin
            o_result = r_acc;
        end else if (r_rem) begin
            o_result = r_rneg ? (32'd0 - r_acc) : r_acc;
        end else begin
            o_result = r_qneg ? (32'd0 - r_sh) : r_sh;
        end
    end
endmodule

// File: src/stack_machine_arith_unit.sv
// Stack machine arithmetic unit: bounded stack, one opcode per item.
// Push/pop/nop, pchar and errors: read the top word (S_TOP, S_TOPW), then emit (S_EMIT);
// div/mul/mod first read both operands and run the one-bit-a-cycle shared arithmetic unit
// (skipped on divide by zero). Pstr reads characters from the top down, then emits a newline.
// Next item accepted the cycle after the last result is registered; a held result
// stalls the sequencer. Sync active-low reset clears count/sequencer, not the memory.
module stack_machine_arith_unit
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sma_if.sink   i_in,
    sma_if.source o_out
);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_DECIDE, S_ALU, S_WB, S_TOP, S_TOPW,
        S_EMIT, S_PRD, S_PWAIT, S_PCHK
    } t_state;

    t_state      r_state;
    logic [31:0] r_mem [STACK_DEPTH];
    logic [5:0]  r_count;
    logic [2:0]  r_op;
    logic [31:0] r_rd;
    logic [31:0] r_a;
    logic [5:0]  r_idx;
    logic [2:0]  r_err;
    logic        r_nl_pending;
    logic [AW-1:0] r_raddr;
    logic        r_ovalid;
    t_out_item   r_oitem;
    logic [6:0]  r_pchar;
    t_alu_ctl    w_ctl;
    logic        w_done;
    logic [31:0] w_res;
    logic        w_out_free;
    logic        w_emit;

    // r_rd holds the top word while the sequencer sits in S_DECIDE
    sma_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_a(r_a), .i_b(r_rd), .o_done(w_done), .o_result(w_res)
    );

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_emit = (r_state == S_EMIT) && w_out_free;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_oitem;

    always_comb begin
        w_ctl.start    = (r_state == S_DECIDE) && (r_op == OP_DIV || r_op == OP_MUL
                         || r_op == OP_MOD) && !(r_op != OP_MUL && r_rd == 32'd0);
        w_ctl.is_mul   = (r_op == OP_MUL);
        w_ctl.want_rem = (r_op == OP_MOD);
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_raddr];
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_op  <= i_in.payload.opcode;
                        r_nl_pending <= 1'b0;
                        case (t_opcode'(i_in.payload.opcode))
                            OP_PUSH: begin
                                if (r_count >= 6'(STACK_DEPTH)) begin
                                    r_err <= ERR_FULL;
                                    r_state <= S_TOP;
                                end else begin
                                    r_err <= ERR_OK;
                                    r_mem[r_count[AW-1:0]] <= i_in.payload.operand_value;
                                    r_count <= r_count + 6'd1;
                                    r_state <= S_TOP;
                                end
                            end
                            OP_POP: begin
                                if (r_count == 6'd0) begin
                                    r_err <= ERR_EMPTY;
                                end else begin
                                    r_err <= ERR_OK;
                                    r_count <= r_count - 6'd1;
                                end
                                r_state <= S_TOP;
                            end
                            OP_DIV, OP_MUL, OP_MOD: begin
                                if (r_count < 6'd2) begin
                                    r_err <= ERR_SHORT;
                                    r_state <= S_TOP;
                                end else begin
                                    r_err <= ERR_OK;
                                    r_raddr <= AW'(r_count - 6'd2);
                                    r_state <= S_RD1;
                                end
                            end
                            OP_PCHAR: begin
                                r_err <= (r_count == 6'd0) ? ERR_EMPTY : ERR_OK;
                                r_state <= S_TOP;
                            end
                            OP_PSTR: begin
                                r_err <= ERR_OK;
                                r_idx <= r_count;
                                r_state <= S_PRD;
                            end
                            default: begin
                                r_err <= ERR_OK;
                                r_state <= S_TOP;
                            end
                        endcase
                    end
                end
                S_RD1: begin
                    r_raddr <= AW'(r_count - 6'd1);
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_a <= r_rd;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_op != OP_MUL && r_rd == 32'd0) begin
                        r_err <= ERR_DIVZERO;
                        r_state <= S_TOP;
                    end else begin
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (w_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_mem[AW'(r_count - 6'd2)] <= w_res;
                    r_count <= r_count - 6'd1;
                    r_state <= S_TOP;
                end
                S_TOP: begin
                    r_raddr <= AW'(r_count - 6'd1);
                    r_state <= S_TOPW;
                end
                S_TOPW: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // r_rd holds the top word; decide pchar here
                    if (w_out_free) begin
                        r_oitem.top_value   <= (r_count == 6'd0) ? 32'd0 : r_rd;
                        r_oitem.stack_count <= r_count;
                        if (r_nl_pending) begin
                            r_oitem.char_valid <= 1'b1;
                            r_oitem.char_code  <= CHAR_NEWLINE;
                            r_oitem.error_code <= r_err;
                            r_oitem.last       <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_op == OP_PSTR) begin
                            r_oitem.char_valid <= 1'b1;
                            r_oitem.char_code  <= r_pchar;
                            r_oitem.error_code <= r_err;
                            r_oitem.last       <= 1'b0;
                            r_state <= S_PRD;
                        end else if (r_op == OP_PCHAR && r_err == ERR_OK
                                     && r_rd <= CHAR_LIMIT) begin
                            r_oitem.char_valid <= 1'b1;
                            r_oitem.char_code  <= r_rd[6:0];
                            r_oitem.error_code <= r_err;
                            r_oitem.last       <= 1'b0;
                            r_nl_pending <= 1'b1;
                            r_state <= S_TOP;
                        end else if (r_op == OP_PCHAR && r_err == ERR_OK) begin
                            r_oitem.char_valid <= 1'b0;
                            r_oitem.char_code  <= '0;
                            r_oitem.error_code <= ERR_RANGE;
                            r_oitem.last       <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_oitem.char_valid <= 1'b0;
                            r_oitem.char_code  <= '0;
                            r_oitem.error_code <= r_err;
                            r_oitem.last       <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PRD: begin
                    if (r_idx == 6'd0) begin
                        r_nl_pending <= 1'b1;
                        r_state <= S_TOP;
                    end else begin
                        r_raddr <= AW'(r_idx - 6'd1);
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (r_rd == 32'd0 || r_rd >= PSTR_BOUND) begin
                        r_nl_pending <= 1'b1;
                        r_state <= S_TOP;
                    end else begin
                        r_pchar <= r_rd[6:0];
                        r_idx   <= r_idx - 6'd1;
                        // emit needs top word: reuse S_EMIT after top read
                        r_state <= S_TOP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // pstr char emission path: after top reread, S_EMIT sees r_op==PSTR
        end
    end
endmodule

// File: test/tb_sma_channels.sv
`timescale 1ns / 1ps
// Testbench-side channel instances are declared in tb_top; this file holds the
// input item helper shared by the test tasks. Depends on sma_pkg.
package tb_sma_util;
    import sma_pkg::*;

    function automatic t_in_item make_item(t_opcode op, logic [31:0] value);
        t_in_item it;
        it.opcode        = op;
        it.operand_value = value;
        return it;
    endfunction
endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for stack_machine_arith_unit: directed and random opcode
// streams, results checked against an in-bench stack predictor.
// Depends on sma_pkg, sma_if, tb_sma_util and the block.
module tb_top;
    import sma_pkg::*;
    import tb_sma_util::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk;
    logic i_rst_n;

    sma_if #(.T(t_in_item))  op_ch ();
    sma_if #(.T(t_out_item)) res_ch ();

    stack_machine_arith_unit #(.STACK_DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    // predictor state
    logic [31:0] shadow_stack [DEPTH];
    int          shadow_count;
    t_out_item   expected_q [$];

    int  fail_count;
    int  items_sent;
    int  results_seen;
    int  cycle_count;
    logic hold_off;        // long receiver stall requested
    int  stall_pattern;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] stack_top();
        return (shadow_count == 0) ? 32'd0 : shadow_stack[shadow_count - 1];
    endfunction

    function automatic void queue_result(logic cv, logic [6:0] code, t_err err);
        t_out_item r;
        r.char_valid  = cv;
        r.char_code   = code;
        r.error_code  = err;
        r.top_value   = stack_top();
        r.stack_count = 6'(shadow_count);
        r.last        = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // Advance the stack copy and queue the results of one opcode.
    function automatic void predict_opcode(t_in_item it);
        t_err err = ERR_OK;
        int   emitted = 0;
        int   idx;
        logic [31:0] a, b, q, res, tv;
        case (t_opcode'(it.opcode))
            OP_PUSH: begin
                if (shadow_count >= DEPTH) err = ERR_FULL;
                else begin
                    shadow_stack[shadow_count] = it.operand_value;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) err = ERR_EMPTY;
                else shadow_count--;
            end
            OP_DIV, OP_MUL, OP_MOD: begin
                if (shadow_count < 2) err = ERR_SHORT;
                else begin
                    b = shadow_stack[shadow_count - 1];
                    a = shadow_stack[shadow_count - 2];
                    if (it.opcode == OP_MUL) res = a * b;
                    else if (b == 0) err = ERR_DIVZERO;
                    else if (it.opcode == OP_DIV) begin
                        q = abs32(a) / abs32(b);
                        res = (a[31] ^ b[31]) ? -q : q;
                    end else begin
                        q = abs32(a) % abs32(b);
                        res = a[31] ? -q : q;
                    end
                    if (err == ERR_OK) begin
                        shadow_stack[shadow_count - 2] = res;
                        shadow_count--;
                    end
                end
            end
            OP_PCHAR: begin
                tv = stack_top();
                if (shadow_count == 0) err = ERR_EMPTY;
                else if (tv > CHAR_LIMIT) err = ERR_RANGE;
                else begin
                    queue_result(1'b1, tv[6:0], ERR_OK);
                    queue_result(1'b1, CHAR_NEWLINE, ERR_OK);
                    emitted = 2;
                end
            end
            OP_PSTR: begin
                idx = shadow_count;
                while (idx > 0 && shadow_stack[idx - 1] != 0
                       && shadow_stack[idx - 1] < PSTR_BOUND) begin
                    queue_result(1'b1, shadow_stack[idx - 1][6:0], ERR_OK);
                    emitted++;
                    idx--;
                end
                queue_result(1'b1, CHAR_NEWLINE, ERR_OK);
                emitted++;
            end
            default: ;
        endcase
        if (emitted == 0) queue_result(1'b0, 7'd0, err);
        expected_q[$].last = 1'b1;
    endfunction

    // Result checker and receiver stall pattern.
    initial begin
        t_out_item got, want;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got = res_ch.payload;
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.char_valid !== want.char_valid) begin
                        $error("char_valid exp %0h got %0h", want.char_valid, got.char_valid);
                        fail_count++;
                    end
                    if (got.char_code !== want.char_code) begin
                        $error("char_code exp %0d got %0d", want.char_code, got.char_code);
                        fail_count++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                        fail_count++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $error("top_value exp %0h got %0h", want.top_value, got.top_value);
                        fail_count++;
                    end
                    if (got.stack_count !== want.stack_count) begin
                        $error("stack_count exp %0d got %0d", want.stack_count,
                               got.stack_count);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0h got %0h", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            // stall on a pattern of its own: mode 0 never stalls
            if (hold_off) res_ch.ready <= 1'b0;
            else case (stall_pattern)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    int burst_left;

    // Offer one item and hold it until accepted; gaps fall between bursts.
    task automatic send_item(t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        predict_opcode(it);
        op_ch.valid   <= 1'b1;
        op_ch.payload <= it;
        do @(posedge i_clk); while (!op_ch.ready);
        items_sent++;
        if (burst_left == 0) op_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0) op_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_value(logic [31:0] v);
        send_item(make_item(OP_PUSH, v));
    endtask

    task automatic test_empty_errors();
        send_item(make_item(OP_POP, 32'hFFFF_FFFF));
        send_item(make_item(OP_PCHAR, 32'd0));
        send_item(make_item(OP_PSTR, 32'd0));
        send_item(make_item(OP_DIV, 32'd0));
        send_item(make_item(OP_NOP, 32'h5555_5555));
        push_value(32'd7);
        send_item(make_item(OP_MOD, 32'd0));
    endtask

    task automatic test_arith_edges();
        push_value(32'h8000_0000);
        push_value(32'hFFFF_FFFF);
        send_item(make_item(OP_DIV, 32'd0));     // most negative / -1 wraps
        push_value(32'hFFFF_FFFF);
        send_item(make_item(OP_MOD, 32'd0));
        push_value(32'd0);
        send_item(make_item(OP_DIV, 32'd0));     // divide by zero
        send_item(make_item(OP_MOD, 32'd0));
        send_item(make_item(OP_POP, 32'd0));
        push_value(32'h7FFF_FFFF);
        send_item(make_item(OP_MUL, 32'd0));
        push_value(-32'sd7);
        send_item(make_item(OP_MOD, 32'd0));
        drain();
    endtask

    task automatic test_chars();
        push_value(32'd200);
        send_item(make_item(OP_PCHAR, 32'd0));   // out of range
        push_value(32'd0);
        send_item(make_item(OP_PCHAR, 32'd0));   // zero still emits
        push_value(32'd127);
        push_value(32'd65);
        send_item(make_item(OP_PCHAR, 32'd0));
        send_item(make_item(OP_PSTR, 32'd0));
        drain();
    endtask

    task automatic test_full_stack();
        while (shadow_count < DEPTH)
            push_value($urandom_range(1, 127));
        push_value(32'hDEAD_BEEF);               // dropped on a full stack
        send_item(make_item(OP_PSTR, 32'd0));    // walk on a full stack
        drain();
    endtask

    // Hold the receiver off while the sender keeps offering items.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (20) send_item(make_item(OP_PSTR, 32'd0));
        join
        drain();
        while (shadow_count > 0) send_item(make_item(OP_POP, 32'd0));
        drain();
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 127);
            1: return $urandom_range(0, 3) - 1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_random(int count);
        t_opcode op;
        logic [31:0] v;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) stall_pattern = $urandom_range(0, 2);
            // bias toward pushes while shallow so deep states are reached
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_PUSH;
                3: op = OP_POP;
                4: op = OP_DIV;
                5: op = OP_MUL;
                6: op = OP_MOD;
                7: op = OP_PCHAR;
                8: op = OP_PSTR;
                default: op = t_opcode'($urandom_range(0, 7));
            endcase
            if (shadow_count < 3 && $urandom_range(0, 1)) op = OP_PUSH;
            v = random_value();
            send_item(make_item(op, v));
            if (n == count / 2) drain();         // sender waits for all results
        end
        drain();
    endtask

    initial begin
        fail_count    = 0;
        items_sent    = 0;
        results_seen  = 0;
        shadow_count  = 0;
        burst_left    = 0;
        hold_off      = 1'b0;
        stall_pattern = 0;
        i_rst_n       <= 1'b0;
        op_ch.valid   <= 1'b0;
        op_ch.payload <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_errors();
        test_arith_edges();
        test_chars();
        stall_pattern = 2;
        test_full_stack();
        test_backpressure();
        test_random(350);

        repeat (100) @(posedge i_clk);
        $display("covered %0d items, %0d results: all opcodes, errors, stack extremes",
                 items_sent, results_seen);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures, %0d left over", fail_count, expected_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/sma_pkg.sv
src/sma_if.sv
src/sma_alu.sv
src/stack_machine_arith_unit.sv
test/tb_sma_channels.sv
test/tb_top.sv
